@@ sv/tvgs_pkg.sv @@
// Shared types and constants for the tract value Gaussian smoother.
package tvgs_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int OUT_W      = 32;
	localparam int WEIGHT_W   = 16;
	localparam int FOLD_W     = WEIGHT_W + 2;
	localparam int INDEX_W    = 16;
	localparam int TAPS       = 5;
	localparam int POS_W      = 3;
	localparam int FILL_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE    = 2'd3;

	localparam logic signed [CFG_DATA_W-1:0] THRESHOLD_RST = 32'sd65536000;
	localparam logic [WEIGHT_W-1:0] OUTER_RST  = 16'd3572;
	localparam logic [WEIGHT_W-1:0] INNER_RST  = 16'd16004;
	localparam logic [WEIGHT_W-1:0] CENTRE_RST = 16'd26385;

	// Window positions and the fill level of a tract.
	localparam logic [POS_W-1:0]  POS_FIRST  = 3'd0;
	localparam logic [POS_W-1:0]  POS_CENTRE = 3'd2;
	localparam logic [POS_W-1:0]  POS_NEWEST = 3'd4;
	localparam logic [FILL_W-1:0] FILL_FOUR  = 3'd4;
	localparam logic [FILL_W-1:0] FILL_FULL  = 3'd5;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       tract_end;
	} tvgs_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] smoothed;
		logic [INDEX_W-1:0]      point_index;
		logic                    passed_raw;
		logic                    final_point;
		logic                    burst_last;
	} tvgs_out_t;

	typedef struct packed {
		logic signed [CFG_DATA_W-1:0] threshold;
		logic [WEIGHT_W-1:0]          outer;
		logic [WEIGHT_W-1:0]          inner;
		logic [WEIGHT_W-1:0]          centre;
	} tvgs_cfg_t;

	// One result to compute: which window entry, and its sideband.
	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic               force_raw;
		logic               final_point;
		logic               burst_last;
		logic [INDEX_W-1:0] point_index;
	} tvgs_slot_t;

	typedef logic [TAPS-1:0][SAMPLE_W-1:0] tvgs_window_t;

endpackage

@@ sv/tvgs_kernel.sv @@
// Two-stage weighted sum of the window: products, then sum, rounding and saturation.
module tvgs_kernel (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tvgs_pkg::tvgs_cfg_t    cfg,
	input  tvgs_pkg::tvgs_window_t window,
	input  logic                  slot_valid,
	output logic                  slot_ready,
	input  tvgs_pkg::tvgs_slot_t   slot,
	output logic                  res_valid,
	input  logic                  res_ready,
	output tvgs_pkg::tvgs_out_t    res
);
	import tvgs_pkg::*;

	localparam int PW    = SAMPLE_W + FOLD_W + 1;
	localparam int SUMW  = PW + 3;
	localparam int FRAC  = 16;
	localparam logic signed [SUMW-1:0] RND    = SUMW'(1) <<< (FRAC - 1);
	localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SUMW-1:0] SAT_LO = {{(SUMW-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

	typedef logic [TAPS-1:0][FOLD_W-1:0] wvec_t;

	// Weights per window entry for a given centre; taps beyond an end fold inward.
	function automatic wvec_t fold_weights(input logic [POS_W-1:0] pos, input tvgs_cfg_t c);
		logic [FOLD_W-1:0] o;
		logic [FOLD_W-1:0] i;
		logic [FOLD_W-1:0] m;
		wvec_t w;
		o = FOLD_W'(c.outer);
		i = FOLD_W'(c.inner);
		m = FOLD_W'(c.centre);
		w = '0;
		case (pos)
			3'd0: begin
				w[0] = m + i + o; w[1] = i; w[2] = o;
			end
			3'd1: begin
				w[0] = i + o; w[1] = m; w[2] = i; w[3] = o;
			end
			3'd2: begin
				w[0] = o; w[1] = i; w[2] = m; w[3] = i; w[4] = o;
			end
			3'd3: begin
				w[1] = o; w[2] = i; w[3] = m; w[4] = i + o;
			end
			3'd4: begin
				w[2] = o; w[3] = i; w[4] = m + i + o;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [TAPS-1:0] used_taps(input logic [POS_W-1:0] pos);
		logic [TAPS-1:0] u;
		case (pos)
			3'd0:    u = 5'b00111;
			3'd1:    u = 5'b01111;
			3'd2:    u = 5'b11111;
			3'd3:    u = 5'b11110;
			3'd4:    u = 5'b11100;
			default: u = 5'b00000;
		endcase
		return u;
	endfunction

	logic                       en1;
	logic                       en2;
	wvec_t                      wv;
	logic [TAPS-1:0]            over;
	logic signed [PW-1:0]       prod_c [TAPS];

	logic                       v_s1;
	logic signed [PW-1:0]       prod_s1 [TAPS];
	logic                       raw_s1;
	logic signed [SAMPLE_W-1:0] rawval_s1;
	logic [INDEX_W-1:0]         index_s1;
	logic                       final_s1;
	logic                       last_s1;

	logic signed [SUMW-1:0]     sum_c;
	logic signed [SUMW-1:0]     rnd_c;
	logic signed [SUMW-1:0]     sat_c;

	logic                       v_s2;
	tvgs_out_t                  res_s2;

	assign en2        = !v_s2 || res_ready;
	assign en1        = !v_s1 || en2;
	assign slot_ready = en1;

	always_comb begin
		wv = fold_weights(slot.pos, cfg);
		for (int j = 0; j < TAPS; j++) begin
			over[j]   = $signed(window[j]) > $signed(cfg.threshold);
			prod_c[j] = $signed(window[j]) * $signed({1'b0, wv[j]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= slot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && slot_valid) begin
			for (int j = 0; j < TAPS; j++) begin
				prod_s1[j] <= prod_c[j];
			end
			raw_s1    <= slot.force_raw || (|(over & used_taps(slot.pos)));
			rawval_s1 <= $signed(window[slot.pos]);
			index_s1  <= slot.point_index;
			final_s1  <= slot.final_point;
			last_s1   <= slot.burst_last;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int j = 0; j < TAPS; j++) begin
			sum_c = sum_c + SUMW'(prod_s1[j]);
		end
		// Round to nearest with ties upward, then clamp to the sample range.
		rnd_c = (sum_c + RND) >>> FRAC;
		if (rnd_c > SAT_HI) begin
			sat_c = SAT_HI;
		end else if (rnd_c < SAT_LO) begin
			sat_c = SAT_LO;
		end else begin
			sat_c = rnd_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			res_s2.smoothed    <= raw_s1 ? OUT_W'(rawval_s1)
			                             : OUT_W'($signed(sat_c[SAMPLE_W-1:0]));
			res_s2.point_index <= index_s1;
			res_s2.passed_raw  <= raw_s1;
			res_s2.final_point <= final_s1;
			res_s2.burst_last  <= last_s1;
		end
	end

	assign res_valid = v_s2;
	assign res       = res_s2;

endmodule

@@ sv/tract_value_gaussian_smoother_core.sv @@
// Top level of the tract value Gaussian smoother: window, sequencer and config registers.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | tvgs_in_t  (sample, tract_end)
//  rsp     | out       | rsp_valid/rsp_ready  | tvgs_out_t (smoothed, index, flags)
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// A request is taken in the cycle its last result is issued, so a steady tract runs at
// one request per cycle while the output is not stalled; the fifth request and the end
// of a tract issue up to five results, one per cycle unless stalled, and hold req_ready
// low meanwhile. An issued result is registered in the product stage, then the sum stage.
// Reset clears the sequencer and loads the default threshold and weights.
// A stalled output holds the pipeline while later requests that need no result still enter.
module tract_value_gaussian_smoother_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  tvgs_pkg::tvgs_in_t                 req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output tvgs_pkg::tvgs_out_t                rsp,
	input  logic                              cfg_we,
	input  logic [tvgs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tvgs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tvgs_pkg::*;

	tvgs_cfg_t          cfg_q;
	tvgs_window_t       window_q;
	logic [FILL_W-1:0]  fill_q;
	logic [INDEX_W-1:0] index_q;
	logic               busy_q;
	logic [POS_W-1:0]   pos_q;
	logic               end_q;
	logic               short_q;

	logic               slot_ready;
	logic               issue;
	logic               last_slot;
	logic               accept;
	tvgs_slot_t         slot;

	// A tract's results end at the centre entry unless the request closed the tract.
	assign last_slot = end_q ? (pos_q == POS_NEWEST) : (pos_q == POS_CENTRE);
	assign issue     = busy_q && slot_ready;
	assign req_ready = !busy_q || (slot_ready && last_slot);
	assign accept    = req_valid && req_ready;

	assign slot.pos         = pos_q;
	assign slot.force_raw   = short_q;
	assign slot.final_point = end_q && (pos_q == POS_NEWEST);
	assign slot.burst_last  = last_slot;
	assign slot.point_index = index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.outer     <= OUTER_RST;
			cfg_q.inner     <= INNER_RST;
			cfg_q.centre    <= CENTRE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= $signed(cfg_data);
				REG_OUTER:     cfg_q.outer     <= cfg_data[WEIGHT_W-1:0];
				REG_INNER:     cfg_q.inner     <= cfg_data[WEIGHT_W-1:0];
				REG_CENTRE:    cfg_q.centre    <= cfg_data[WEIGHT_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < TAPS - 1; j++) begin
				window_q[j] <= window_q[j+1];
			end
			window_q[TAPS-1] <= req.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			busy_q  <= 1'b0;
			pos_q   <= '0;
			end_q   <= 1'b0;
			short_q <= 1'b0;
		end else if (accept) begin
			if (fill_q < FILL_FOUR) begin
				if (req.tract_end) begin
					// Short tract: every point goes out raw, oldest first.
					busy_q  <= 1'b1;
					pos_q   <= POS_NEWEST - fill_q;
					end_q   <= 1'b1;
					short_q <= 1'b1;
					fill_q  <= '0;
				end else begin
					busy_q <= 1'b0;
					fill_q <= fill_q + 3'd1;
				end
			end else begin
				busy_q  <= 1'b1;
				pos_q   <= (fill_q == FILL_FOUR) ? POS_FIRST : POS_CENTRE;
				end_q   <= req.tract_end;
				short_q <= 1'b0;
				fill_q  <= req.tract_end ? '0 : FILL_FULL;
			end
		end else if (issue) begin
			if (last_slot) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (issue) begin
			if (slot.final_point) begin
				index_q <= '0;
			end else if (index_q != {INDEX_W{1'b1}}) begin
				index_q <= index_q + 16'd1;
			end
		end
	end

	tvgs_kernel u_kernel (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.window     (window_q),
		.slot_valid (busy_q),
		.slot_ready (slot_ready),
		.slot       (slot),
		.res_valid  (rsp_valid),
		.res_ready  (rsp_ready),
		.res        (rsp)
	);

endmodule

@@ sv/tvgs_checker.sv @@
// Port-level checks on the smoother's result stream, bound to the top level.
module tvgs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input tvgs_pkg::tvgs_out_t rsp
);
	import tvgs_pkg::*;

	logic rsp_take;
	assign rsp_take = rsp_valid && rsp_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	a_final_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.final_point |-> rsp.burst_last)
		else $error("final point of a tract is not the end of its burst");

	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && !rsp.burst_last |=> rsp_valid)
		else $error("gap inside a burst of results");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && !rsp.burst_last |=>
			(rsp.point_index == $past(rsp.point_index) + 16'd1) ||
			($past(rsp.point_index) == {INDEX_W{1'b1}}))
		else $error("point index did not advance within a burst");

	a_new_tract_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && rsp.final_point |=> !rsp_valid || (rsp.point_index == '0))
		else $error("first result of a new tract has a nonzero index");

endmodule

bind tract_value_gaussian_smoother_core tvgs_checker u_tvgs_checker (.*);

@@ bench/tract_value_gaussian_smoother_core_tb.sv @@
// Self-checking bench for the tract value Gaussian smoother: scripted tracts, then random ones.
`timescale 1ns / 100ps

module tract_value_gaussian_smoother_core_tb;
	import tvgs_pkg::*;

	localparam int unsigned RUN_LIMIT  = 1_000_000;
	localparam int unsigned SETTLE     = 8;
	localparam int unsigned REPORT_CAP = 40;
	localparam int unsigned SCRIPT_LEN = 20;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic [INDEX_W-1:0] INDEX_TOP = 16'hFFFF;
	localparam logic [WEIGHT_W-1:0] W_FULL = 16'hFFFF;
	localparam logic [WEIGHT_W-1:0] W_NONE = 16'h0000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       tract_end;
		logic                       typed;
		tvgs_out_t                  want;
	} script_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	tvgs_in_t              req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	tvgs_out_t             rsp;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	bit          gaps_on     = 1'b1;
	int unsigned cycle_count = 0;
	int unsigned bad_fields  = 0;

	// Mirror of the smoother: registers, sample window, tract position.
	logic signed [SAMPLE_W-1:0] thr_q    = THRESHOLD_RST;
	logic [WEIGHT_W-1:0]        w_outer  = OUTER_RST;
	logic [WEIGHT_W-1:0]        w_inner  = INNER_RST;
	logic [WEIGHT_W-1:0]        w_centre = CENTRE_RST;
	logic signed [SAMPLE_W-1:0] taps [TAPS] = '{default: '0};
	int unsigned                fill_q     = 0;
	logic [INDEX_W-1:0]         next_index = '0;
	tvgs_out_t                  smoothed_due [$];

	// Single-point tracts come back raw and unchanged, so their results are written out here.
	script_row_t opening_script [SCRIPT_LEN] = '{
		'{S_MAX,          1'b1, 1'b1, '{S_MAX, 16'd0, 1'b1, 1'b1, 1'b1}},
		'{S_MIN,          1'b1, 1'b1, '{S_MIN, 16'd0, 1'b1, 1'b1, 1'b1}},
		'{32'sh0000_0000, 1'b1, 1'b1, '{32'sh0, 16'd0, 1'b1, 1'b1, 1'b1}},
		'{32'sh0001_0000, 1'b0, 1'b0, '0},
		'{32'sh0002_0000, 1'b1, 1'b0, '0},
		'{32'shFFFF_0000, 1'b0, 1'b0, '0},
		'{32'sh0000_8000, 1'b0, 1'b0, '0},
		'{S_MAX,          1'b0, 1'b0, '0},
		'{S_MIN,          1'b1, 1'b0, '0},
		'{32'sh0003_0000, 1'b0, 1'b0, '0},
		'{32'shFFFD_8000, 1'b0, 1'b0, '0},
		'{32'sh0000_0001, 1'b0, 1'b0, '0},
		'{32'shFFFF_FFFF, 1'b0, 1'b0, '0},
		'{32'sh0005_0000, 1'b1, 1'b0, '0},
		'{32'sh0001_0000, 1'b0, 1'b0, '0},
		'{32'sh03E8_0000, 1'b0, 1'b0, '0},
		'{32'sh0003_0000, 1'b0, 1'b0, '0},
		'{32'sh0004_0000, 1'b0, 1'b0, '0},
		'{32'sh0005_0000, 1'b0, 1'b0, '0},
		'{32'sh03E8_0001, 1'b1, 1'b0, '0}
	};

	tract_value_gaussian_smoother_core dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic log_mismatch(input string what);
		if (bad_fields < REPORT_CAP)
			$display("%0t mismatch: %s", $time, what);
		bad_fields++;
	endtask

	function automatic void queue_point(input logic signed [SAMPLE_W-1:0] value,
			input logic raw, input logic fin, input logic last);
		tvgs_out_t r;
		r.smoothed    = value;
		r.point_index = next_index;
		r.passed_raw  = raw;
		r.final_point = fin;
		r.burst_last  = last;
		smoothed_due = {smoothed_due, r};
		if (next_index != INDEX_TOP)
			next_index++;
	endfunction

	// Value for window entry c, with nl tract points to its left and nr to its right.
	function automatic void smooth_point(input int c, input int nl, input int nr,
			input logic fin, input logic last);
		longint wt [TAPS];
		longint acc;
		logic   raw;
		raw = 1'b0;
		acc = 0;
		for (int d = -nl; d <= nr; d++)
			if (taps[c + d] > thr_q)
				raw = 1'b1;
		if (raw) begin
			queue_point(taps[c], 1'b1, fin, last);
			return;
		end
		wt[0] = w_outer;
		wt[1] = w_inner;
		wt[2] = w_centre;
		wt[3] = w_inner;
		wt[4] = w_outer;
		// Taps beyond an end of the tract give their weight to the nearest tap inside it.
		if (nl == 1) begin
			wt[1] += wt[0];
			wt[0] = 0;
		end
		if (nl == 0) begin
			wt[2] += wt[0] + wt[1];
			wt[0] = 0;
			wt[1] = 0;
		end
		if (nr == 1) begin
			wt[3] += wt[4];
			wt[4] = 0;
		end
		if (nr == 0) begin
			wt[2] += wt[3] + wt[4];
			wt[3] = 0;
			wt[4] = 0;
		end
		for (int d = -nl; d <= nr; d++)
			acc += longint'(taps[c + d]) * wt[d + 2];
		// Round half up out of Q16.32, then clamp to the sample range.
		acc = (acc + 64'sd32768) >>> 16;
		if (acc > longint'(S_MAX))
			acc = S_MAX;
		if (acc < longint'(S_MIN))
			acc = S_MIN;
		queue_point(acc[SAMPLE_W-1:0], 1'b0, fin, last);
	endfunction

	function automatic void advance_tract(input tvgs_in_t item);
		int m;
		for (int i = 0; i < TAPS - 1; i++)
			taps[i] = taps[i + 1];
		taps[TAPS - 1] = item.sample;
		if (fill_q < FILL_FOUR) begin
			if (!item.tract_end) begin
				fill_q++;
				return;
			end
			// A tract too short for the kernel leaves raw, all on its last request.
			m = fill_q + 1;
			for (int i = 0; i < m; i++)
				queue_point(taps[TAPS - m + i], 1'b1, i == m - 1, i == m - 1);
			fill_q = 0;
			next_index = '0;
			return;
		end
		if (fill_q == FILL_FOUR) begin
			fill_q = FILL_FULL;
			smooth_point(0, 0, 2, 1'b0, 1'b0);
			smooth_point(1, 1, 2, 1'b0, 1'b0);
		end
		smooth_point(2, 2, 2, 1'b0, !item.tract_end);
		if (item.tract_end) begin
			smooth_point(3, 2, 1, 1'b0, 1'b0);
			smooth_point(4, 2, 0, 1'b1, 1'b1);
			fill_q = 0;
			next_index = '0;
		end
	endfunction

	task automatic push_request(input tvgs_in_t item);
		while (gaps_on && $urandom_range(99) < 29) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		advance_tract(item);
	endtask

	task automatic check_result(input tvgs_out_t got);
		tvgs_out_t want;
		if (smoothed_due.size() == 0) begin
			log_mismatch($sformatf("result %h arrived with nothing predicted", got));
			return;
		end
		want = smoothed_due.pop_front();
		if (got.smoothed !== want.smoothed)
			log_mismatch($sformatf("point %0d: smoothed %h, predicted %h",
				want.point_index, got.smoothed, want.smoothed));
		if (got.point_index !== want.point_index)
			log_mismatch($sformatf("point_index %0d, predicted %0d",
				got.point_index, want.point_index));
		if (got.passed_raw !== want.passed_raw)
			log_mismatch($sformatf("point %0d: passed_raw %b, predicted %b",
				want.point_index, got.passed_raw, want.passed_raw));
		if (got.final_point !== want.final_point)
			log_mismatch($sformatf("point %0d: final_point %b, predicted %b",
				want.point_index, got.final_point, want.final_point));
		if (got.burst_last !== want.burst_last)
			log_mismatch($sformatf("point %0d: burst_last %b, predicted %b",
				want.point_index, got.burst_last, want.burst_last));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_result(rsp);
		rsp_ready <= !(gaps_on && $urandom_range(99) < 29);
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Registers change only once the smoother has drained.
	task automatic apply_setting(input logic signed [SAMPLE_W-1:0] thr,
			input logic [WEIGHT_W-1:0] outer, input logic [WEIGHT_W-1:0] inner,
			input logic [WEIGHT_W-1:0] centre);
		req_valid <= 1'b0;
		while (smoothed_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_register(REG_THRESHOLD, thr);
		write_register(REG_OUTER, {16'd0, outer});
		write_register(REG_INNER, {16'd0, inner});
		write_register(REG_CENTRE, {16'd0, centre});
		cfg_we <= 1'b0;
		thr_q = thr;
		w_outer = outer;
		w_inner = inner;
		w_centre = centre;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		longint near;
		case ($urandom_range(19))
			0: return $urandom_range(1) ? S_MAX : S_MIN;
			1, 2: return $urandom();
			3, 4: begin
				// Values on and around the outlier threshold.
				near = longint'(thr_q) + longint'($urandom_range(4)) - 2;
				if (near > longint'(S_MAX))
					near = S_MAX;
				if (near < longint'(S_MIN))
					near = S_MIN;
				return near[SAMPLE_W-1:0];
			end
			default: return int'($urandom_range(32'hFF_FFFF)) - 32'sh80_0000;
		endcase
	endfunction

	task automatic run_tracts(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		tvgs_in_t    item;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4: len = $urandom_range(4, 1);
				5, 6, 7: len = $urandom_range(40, 13);
				default: len = $urandom_range(12, 5);
			endcase
			for (int unsigned i = 0; i < len; i++) begin
				item.sample = pick_sample();
				item.tract_end = (i == len - 1);
				push_request(item);
			end
			sent += len;
		end
	endtask

	initial begin
		tvgs_in_t item;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The opening tracts run on the reset threshold and weights.
		for (int k = 0; k < SCRIPT_LEN; k++) begin
			item.sample = opening_script[k].sample;
			item.tract_end = opening_script[k].tract_end;
			push_request(item);
			if (opening_script[k].typed)
				smoothed_due[$] = opening_script[k].want;
		end

		// Heaviest weights with no outliers possible: large samples drive the sums into saturation.
		apply_setting(S_MAX, W_FULL, W_FULL, W_FULL);
		run_tracts(70);

		// Lowest threshold: nearly every window holds an outlier.
		apply_setting(S_MIN, W_NONE, W_NONE, W_NONE);
		run_tracts(50);

		apply_setting(32'sh0064_0000, W_NONE, W_NONE, W_FULL);
		gaps_on = 1'b0;
		run_tracts(70);
		gaps_on = 1'b1;

		apply_setting(THRESHOLD_RST, OUTER_RST, INNER_RST, CENTRE_RST);
		run_tracts(70);

		repeat (3) begin
			apply_setting($urandom(), WEIGHT_W'($urandom_range(W_FULL)),
				WEIGHT_W'($urandom_range(W_FULL)), WEIGHT_W'($urandom_range(W_FULL)));
			run_tracts(50);
		end

		req_valid <= 1'b0;
		while (smoothed_due.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE) @(posedge clk);

		if (bad_fields == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/tvgs_pkg.sv
sv/tvgs_kernel.sv
sv/tract_value_gaussian_smoother_core.sv
sv/tvgs_checker.sv
bench/tract_value_gaussian_smoother_core_tb.sv
